### rtl/tfg_pkg.sv
// shared types, constants and crc helper for the link-test frame generator
// no dependencies; imported by every module of the block
package tfg_pkg;

    // frame layout
    localparam int unsigned MAX_PAYLOAD  = 4096;
    localparam int unsigned LEN_W        = 13;
    localparam int unsigned POS_W        = 13;
    localparam int unsigned HEADER_BYTES = 8;
    localparam int unsigned MAGIC_BYTES  = 4;

    // crc-32, reflected form
    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

    // configuration reset values
    localparam logic [31:0]      MAGIC_RESET       = 32'hA55A_5AA5;
    localparam logic [LEN_W-1:0] PAYLOAD_LEN_RESET = LEN_W'(256);
    localparam logic [31:0]      FRAME_TOTAL_RESET = 32'd1_000_000;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_MAGIC_WORD     = 2'd0,
        CFG_PAYLOAD_LENGTH = 2'd1,
        CFG_FRAME_TOTAL    = 2'd2
    } cfg_index_t;

    // tuser bit positions on the result channel
    localparam int unsigned TUSER_FIRST = 0;
    localparam int unsigned TUSER_DONE  = 1;

    typedef struct packed {
        logic [31:0]      magic_word;
        logic [LEN_W-1:0] payload_length;
        logic [31:0]      frame_total;
    } cfg_t;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        frame_first;
        logic        frame_last;
        logic        run_done;
        logic [31:0] frame_number;
    } result_t;

    // one byte of reflected crc update, eight shift steps
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
        end
        return c;
    endfunction

    // pick byte sel of a 32-bit word, low byte first
    function automatic logic [7:0] word_byte(input logic [31:0] w, input logic [1:0] sel);
        logic [7:0] b;
        unique case (sel)
            2'd0: b = w[7:0];
            2'd1: b = w[15:8];
            2'd2: b = w[23:16];
            default: b = w[31:24];
        endcase
        return b;
    endfunction

endpackage

### rtl/test_frame_generator_crc32.sv
// top level of the link-test frame generator with crc-32 trailer
// depends on tfg_pkg, tfg_cfg_regs and tfg_engine
//
//  channel  | direction | tdata                          | tuser / tlast
//  ---------+-----------+--------------------------------+---------------------------
//  s_       | in        | [0] restart                    | none
//  m_       | out       | [7:0] byte, [39:8] frame no.   | tuser [0] first [1] done, tlast last
//  cfg_     | in        | wdata: 0 magic, 1 length, 2 frames (index in cfg_addr)
//
// one transaction per cycle sustained while m_ is not stalled; an input passes the
// input register, then the byte and crc logic into the result register
// the single-byte crc update between those registers sets the clock limit
// aresetn is synchronous; it clears the handshake state, the run state and
// the configuration; there is no clearing pass
// a stall on m_ fills the input register once, then s_tready falls
module test_frame_generator_crc32
    import tfg_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // input channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,     // [0] restart, rest zero
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,     // [7:0] data_byte, [39:8] frame_number
    output logic [1:0]  m_tuser,     // [0] frame_first, [1] run_done
    output logic        m_tlast,     // frame_last
    // configuration write port
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [31:0] cfg_wdata
);

    logic    in_valid_reg, in_valid_next;
    logic    restart_reg;
    logic    out_valid_reg, out_valid_next;
    result_t out_res_reg;
    result_t res;
    cfg_t    cfg;
    logic    out_free;
    logic    step;
    logic    s_accept;

    // pipeline flow control
    assign out_free = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;
    assign s_accept = s_tvalid && s_tready;

    tfg_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    tfg_engine u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (step),
        .restart (restart_reg),
        .cfg     (cfg),
        .result  (res)
    );

    // valid bits of both stages
    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (step) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (step) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            restart_reg <= s_tdata[0];
        end
        if (step) begin
            out_res_reg <= res;
        end
    end

    // result channel
    assign m_tvalid             = out_valid_reg;
    assign m_tdata              = {out_res_reg.frame_number, out_res_reg.data_byte};
    assign m_tuser[TUSER_FIRST] = out_res_reg.frame_first;
    assign m_tuser[TUSER_DONE]  = out_res_reg.run_done;
    assign m_tlast              = out_res_reg.frame_last;

`ifndef ASSERT_OFF
    // a done result carries no frame byte or frame marker
    a_done_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[TUSER_DONE]) |->
        (m_tdata[7:0] == 8'd0 && !m_tlast && !m_tuser[TUSER_FIRST]))
        else $error("done result carries frame data");

    // no frame is both started and ended on one byte
    a_first_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tlast && m_tuser[TUSER_FIRST]))
        else $error("first and last marker on the same byte");

    // a held input item is not dropped while the result stage is blocked
    a_hold_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !out_free) |=> in_valid_reg)
        else $error("input item lost during stall");

    // after a frame end the next byte of the same run starts a frame
    a_frame_follow: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && res.frame_last) |=> (!in_valid_reg || res.run_done || res.frame_first))
        else $error("frame end not followed by frame start");
`endif

endmodule

### rtl/tfg_cfg_regs.sv
// configuration registers of the frame generator: magic, length, frame count
// depends on tfg_pkg
module tfg_cfg_regs
    import tfg_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [31:0] cfg_wdata,
    output cfg_t        cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // register write decode
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index_t'(cfg_addr))
                CFG_MAGIC_WORD:     cfg_next.magic_word     = cfg_wdata;
                CFG_PAYLOAD_LENGTH: cfg_next.payload_length = cfg_wdata[LEN_W-1:0];
                CFG_FRAME_TOTAL:    cfg_next.frame_total    = cfg_wdata;
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.magic_word     <= MAGIC_RESET;
            cfg_reg.payload_length <= PAYLOAD_LEN_RESET;
            cfg_reg.frame_total    <= FRAME_TOTAL_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### rtl/tfg_engine.sv
// frame state (sequence, position, crc, done) and next-byte logic
// depends on tfg_pkg; advances once per step_en
module tfg_engine
    import tfg_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    step_en,
    input  logic    restart,
    input  cfg_t    cfg,
    output result_t result
);

    logic [31:0]      seq_reg, seq_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [31:0]      crc_reg, crc_next;
    logic             fin_reg, fin_next;

    logic [31:0]      seq_cur;
    logic [POS_W-1:0] pos_cur;
    logic [31:0]      crc_cur;
    logic             fin_cur;
    logic             done;
    logic [LEN_W-1:0] len_eff;
    logic [POS_W:0]   pos_ext;
    logic [POS_W:0]   hdr_end;
    logic [POS_W:0]   crc_off;
    logic [1:0]       crc_idx;
    logic [7:0]       byte_val;
    logic             is_crc;
    logic             is_last;

    // restart clears the run before this item is worked
    always_comb begin
        seq_cur = restart ? 32'd0 : seq_reg;
        pos_cur = restart ? '0 : pos_reg;
        crc_cur = restart ? CRC_INIT : crc_reg;
        fin_cur = restart ? 1'b0 : fin_reg;
        done    = fin_cur || ((pos_cur == '0) && (seq_cur >= cfg.frame_total));
    end

    // clamp the payload length into its legal range
    always_comb begin
        if (cfg.payload_length == '0) begin
            len_eff = LEN_W'(1);
        end else if ({1'b0, cfg.payload_length} > (LEN_W+1)'(MAX_PAYLOAD)) begin
            len_eff = LEN_W'(MAX_PAYLOAD);
        end else begin
            len_eff = cfg.payload_length;
        end
    end

    // byte selection by frame position
    always_comb begin
        pos_ext = {1'b0, pos_cur};
        hdr_end = {1'b0, len_eff} + (POS_W+1)'(HEADER_BYTES);
        crc_off = pos_ext - hdr_end;
        crc_idx = (crc_off > (POS_W+1)'(3)) ? 2'd3 : crc_off[1:0];
        is_crc  = 1'b0;
        priority if (pos_ext < (POS_W+1)'(MAGIC_BYTES)) begin
            byte_val = word_byte(cfg.magic_word, pos_cur[1:0]);
        end else if (pos_ext < (POS_W+1)'(HEADER_BYTES)) begin
            byte_val = word_byte(seq_cur, pos_cur[1:0]);
        end else if (pos_ext < hdr_end) begin
            byte_val = pos_cur[7:0] - 8'(HEADER_BYTES);
        end else begin
            byte_val = word_byte(~crc_cur, crc_idx);
            is_crc   = 1'b1;
        end
        is_last = is_crc && (crc_idx == 2'd3);
    end

    // next state
    always_comb begin
        seq_next = seq_cur;
        pos_next = pos_cur;
        crc_next = crc_cur;
        fin_next = done;
        if (!done) begin
            if (is_last) begin
                seq_next = seq_cur + 32'd1;
                pos_next = '0;
                crc_next = CRC_INIT;
            end else begin
                pos_next = pos_cur + POS_W'(1);
                if (!is_crc) begin
                    crc_next = crc_byte(crc_cur, byte_val);
                end
            end
        end
    end

    // result of the current item
    always_comb begin
        result.frame_number = seq_cur;
        result.run_done     = done;
        result.data_byte    = done ? 8'd0 : byte_val;
        result.frame_first  = !done && (pos_cur == '0);
        result.frame_last   = !done && is_last;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_reg <= 32'd0;
            pos_reg <= '0;
            crc_reg <= CRC_INIT;
            fin_reg <= 1'b0;
        end else if (step_en) begin
            seq_reg <= seq_next;
            pos_reg <= pos_next;
            crc_reg <= crc_next;
            fin_reg <= fin_next;
        end
    end

endmodule

### test/frame_byte_checker.sv
// checker for the link-test frame generator: predicts each frame byte and compares results
// depends on tfg_pkg; instantiated beside the block by test_frame_generator_crc32_tb
module frame_byte_checker
    import tfg_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,     // [0] restart
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,     // [7:0] data_byte, [39:8] frame_number
    input  logic [1:0]  m_tuser,     // [0] frame_first, [1] run_done
    input  logic        m_tlast,     // frame_last
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [31:0] cfg_wdata,
    output int          error_count,
    output int          pending,
    output int          ticks_seen,
    output int          frames_closed,
    output int          done_seen
);

    // configuration copy
    logic [31:0]      magic_cfg;
    logic [LEN_W-1:0] payload_len_cfg;
    logic [31:0]      frame_total_cfg;

    // generator state copy
    logic [31:0]      seq_no;
    logic [POS_W-1:0] byte_pos;
    logic [31:0]      crc_acc;
    logic             run_over;

    // expected frame bytes, oldest first
    result_t pending_bytes[$];

    initial begin
        error_count   = 0;
        pending       = 0;
        ticks_seen    = 0;
        frames_closed = 0;
        done_seen     = 0;
    end

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        if (error_count < 30)
            $display("mismatch: %s got 0x%08h want 0x%08h (tick %0d)",
                     what, got, want, ticks_seen);
        error_count++;
    endtask

    // reflected crc-32, one bit per shift, lsb first
    function automatic logic [31:0] crc_fold(input logic [31:0] acc, input logic [7:0] b);
        logic [31:0] r;
        r = acc ^ {24'd0, b};
        repeat (8) r = (r >> 1) ^ (r[0] ? CRC_POLY : 32'd0);
        return r;
    endfunction

    // next byte of the frame stream for one input transaction
    task automatic produce_byte(input logic restart, output result_t r);
        int unsigned span;
        int unsigned p;
        int unsigned idx;
        logic [31:0] fin;
        r = '0;
        if (restart) begin
            seq_no   = '0;
            byte_pos = '0;
            crc_acc  = CRC_INIT;
            run_over = 1'b0;
        end
        // run end only checked at a frame boundary
        if (!run_over && byte_pos == 0 && seq_no >= frame_total_cfg)
            run_over = 1'b1;
        if (run_over) begin
            r.run_done     = 1'b1;
            r.frame_number = seq_no;
            return;
        end
        span = 32'(payload_len_cfg);
        if (span < 1) span = 1;
        if (span > MAX_PAYLOAD) span = MAX_PAYLOAD;
        p = 32'(byte_pos);
        if (p < MAGIC_BYTES) begin
            r.data_byte   = 8'(magic_cfg >> (8 * p));
            r.frame_first = (p == 0);
        end else if (p < HEADER_BYTES) begin
            r.data_byte = 8'(seq_no >> (8 * (p - MAGIC_BYTES)));
        end else if (p < HEADER_BYTES + span) begin
            r.data_byte = 8'(p - HEADER_BYTES);
        end else begin
            // trailer; a shortened layout jumps straight to the last crc byte
            idx = p - HEADER_BYTES - span;
            if (idx > 3) idx = 3;
            fin = ~crc_acc;
            r.data_byte  = 8'(fin >> (8 * idx));
            r.frame_last = (idx == 3);
        end
        if (p < HEADER_BYTES + span) begin
            crc_acc  = crc_fold(crc_acc, r.data_byte);
            byte_pos = POS_W'(p + 1);
        end else if (r.frame_last) begin
            byte_pos = '0;
            crc_acc  = CRC_INIT;
        end else begin
            byte_pos = POS_W'(p + 1);
        end
        r.frame_number = seq_no;
        if (r.frame_last) seq_no = seq_no + 32'd1;
    endtask

    // watch both channels and the register port
    always @(posedge aclk) begin : watch
        result_t got;
        result_t want;
        if (!aresetn) begin
            magic_cfg       = MAGIC_RESET;
            payload_len_cfg = PAYLOAD_LEN_RESET;
            frame_total_cfg = FRAME_TOTAL_RESET;
            seq_no          = '0;
            byte_pos        = '0;
            crc_acc         = CRC_INIT;
            run_over        = 1'b0;
            pending_bytes.delete();
        end else begin
            // result transaction against the oldest expectation
            if (m_tvalid && m_tready) begin
                got.data_byte    = m_tdata[7:0];
                got.frame_number = m_tdata[39:8];
                got.frame_first  = m_tuser[TUSER_FIRST];
                got.run_done     = m_tuser[TUSER_DONE];
                got.frame_last   = m_tlast;
                if (got.frame_last) frames_closed++;
                if (got.run_done) done_seen++;
                if (pending_bytes.size() == 0) begin
                    flag_mismatch("result with nothing outstanding", m_tdata[31:0], 32'd0);
                end else begin
                    want = pending_bytes.pop_front();
                    if (got.data_byte !== want.data_byte)
                        flag_mismatch("data_byte", 32'(got.data_byte),
                                      32'(want.data_byte));
                    if (got.frame_first !== want.frame_first)
                        flag_mismatch("frame_first", 32'(got.frame_first),
                                      32'(want.frame_first));
                    if (got.frame_last !== want.frame_last)
                        flag_mismatch("frame_last", 32'(got.frame_last),
                                      32'(want.frame_last));
                    if (got.run_done !== want.run_done)
                        flag_mismatch("run_done", 32'(got.run_done), 32'(want.run_done));
                    if (got.frame_number !== want.frame_number)
                        flag_mismatch("frame_number", got.frame_number, want.frame_number);
                end
            end
            // register writes
            if (cfg_wr_en) begin
                case (cfg_index_t'(cfg_addr))
                    CFG_MAGIC_WORD:     magic_cfg       = cfg_wdata;
                    CFG_PAYLOAD_LENGTH: payload_len_cfg = cfg_wdata[LEN_W-1:0];
                    CFG_FRAME_TOTAL:    frame_total_cfg = cfg_wdata;
                    default: ;
                endcase
            end
            // input transaction
            if (s_tvalid && s_tready) begin
                produce_byte(s_tdata[0], want);
                pending_bytes.push_back(want);
                ticks_seen++;
            end
        end
        pending = pending_bytes.size();
    end

endmodule

### test/test_frame_generator_crc32_tb.sv
// testbench top for the link-test frame generator: clock, reset, stimulus and verdict
// depends on tfg_pkg, test_frame_generator_crc32 and frame_byte_checker
module test_frame_generator_crc32_tb;
    import tfg_pkg::*;

    localparam int CYCLE_LIMIT = 200_000;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = 8'd0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [39:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_addr  = 2'd0;
    logic [31:0] cfg_wdata = 32'd0;

    int error_count;
    int pending;
    int ticks_seen;
    int frames_closed;
    int done_seen;
    int settings_done = 0;
    int cycles = 0;
    bit steady = 1'b0;

    test_frame_generator_crc32 dut (
        .aclk, .aresetn,
        .s_tvalid, .s_tready, .s_tdata,
        .m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast,
        .cfg_wr_en, .cfg_addr, .cfg_wdata
    );

    frame_byte_checker checker_i (
        .aclk, .aresetn,
        .s_tvalid, .s_tready, .s_tdata,
        .m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast,
        .cfg_wr_en, .cfg_addr, .cfg_wdata,
        .error_count, .pending, .ticks_seen, .frames_closed, .done_seen
    );

    // clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // receiver stalls at random unless in a steady stretch
    always @(negedge aclk) begin
        m_tready <= steady || ($urandom_range(99) >= 13);
    end

    // all three registers, one per cycle, then write enable low
    task automatic set_config(input logic [31:0] magic, input logic [31:0] len,
                              input logic [31:0] total);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= CFG_MAGIC_WORD;
        cfg_wdata <= magic;
        @(negedge aclk);
        cfg_addr  <= CFG_PAYLOAD_LENGTH;
        cfg_wdata <= len;
        @(negedge aclk);
        cfg_addr  <= CFG_FRAME_TOTAL;
        cfg_wdata <= total;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
        settings_done++;
    endtask

    // one input transaction, with random idle cycles in front
    task automatic push_tick(input logic restart);
        while (!steady && $urandom_range(99) < 13) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, restart};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // stop sending and let every outstanding byte come back
    task automatic drain_and_wait(input int tail);
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (pending != 0) @(negedge aclk);
        repeat (tail) @(negedge aclk);
    endtask

    initial begin : stimulus
        int          n;
        logic [31:0] len;
        logic [31:0] total;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: zero magic, zero length used as one, single-frame run
        set_config(32'h0000_0000, 32'd0, 32'd1);
        push_tick(1'b1);
        repeat (12) push_tick(1'b0);
        repeat (2) push_tick(1'b0);       // run done
        push_tick(1'b1);                  // restart out of done
        repeat (3) push_tick(1'b0);
        push_tick(1'b1);                  // restart mid-frame
        repeat (2) push_tick(1'b0);
        drain_and_wait(4);

        // oversized length setting; long stretch without idling
        set_config(32'hFFFF_FFFF, 32'd8191, 32'hFFFF_FFFF);
        push_tick(1'b1);
        for (int i = 0; i < 300; i++) begin
            steady = (i < 200);
            push_tick(1'b0);
        end
        steady = 1'b0;
        drain_and_wait(4);

        // length lowered while deep into a frame: last crc byte ends it
        set_config(32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF);
        repeat (3) push_tick(1'b0);
        drain_and_wait(4);

        // zero frame total: done at once, also after a restart
        set_config(32'h1234_5678, 32'd4, 32'd0);
        repeat (2) push_tick(1'b0);
        push_tick(1'b1);
        push_tick(1'b0);
        drain_and_wait(4);

        // random settings, mostly short frames and short runs
        for (int ph = 0; ph < 8; ph++) begin
            case ($urandom_range(9))
                0:       len = 32'd0;
                1:       len = $urandom_range(300, 250);
                default: len = $urandom_range(24, 1);
            endcase
            total = ($urandom_range(4) == 0) ? $urandom : $urandom_range(5, 1);
            set_config($urandom, len, total);
            n = 0;
            if ($urandom_range(3) != 0) begin
                push_tick(1'b1);
                n = 1;
            end
            while (n < 100) begin
                push_tick($urandom_range(99) < 2);
                n++;
            end
            drain_and_wait(4);
        end

        repeat (8) @(negedge aclk);
        $display("run covered %0d ticks, %0d frames closed by a crc trailer, %0d done results",
                 ticks_seen, frames_closed, done_seen);
        $display("over %0d register settings, payload length 0 to 8191, frame total 0 to max",
                 settings_done);
        if (error_count == 0 && pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
